/* design/hcbs_pkg.sv */
// shared types and constants of the histogram class binning scaler
package hcbs_pkg;

  localparam int NUM_BINS       = 256;
  localparam int BINS_PER_CLASS = 8;
  localparam int NUM_CLASSES    = 32;
  localparam int COUNT_BITS     = 16;

  localparam int SAMPLE_W = 12;
  localparam int SCALE_W  = 16;
  localparam int TOTAL_W  = 19;
  localparam int CLASS_W  = 5;

  localparam int BIN_W  = $clog2(NUM_BINS);
  localparam int SUB_W  = $clog2(BINS_PER_CLASS);
  localparam int STEP_W = $clog2(TOTAL_W + 1);

  localparam logic [SAMPLE_W-1:0] BIN_LIMIT = SAMPLE_W'(NUM_BINS);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_value;
    logic                last_sample;
  } sample_t;

  typedef struct packed {
    logic [CLASS_W-1:0] class_index;
    logic [TOTAL_W-1:0] class_total;
    logic [TOTAL_W-1:0] star_count;
    logic               last_class;
  } result_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_INC  = 6'b000010,
    ST_SUM  = 6'b000100,
    ST_ADD  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

endpackage

/* design/histogram_class_binning_scaler.sv */
// top level: bin counter store, class summing and shared bit-serial divider
//
// Samples arrive as transactions on sample_valid / sample_ready with payload sample.
// Each in-range value bumps its saturating 16-bit bin counter (a read then a write of
// the bin memory); an out-of-range value leaves the store unchanged. On a sample
// flagged last_sample the block reads out: for each of the 32 classes it reads and sums
// the eight bins through the single memory read port, then divides the total by scale
// in a restoring divider, one quotient bit per cycle, then loads the output register;
// sample_ready stays low throughout.
// Results leave as transactions on result_valid / result_ready with payload result.
// A stalled receiver holds the output register; the readout then waits before loading
// the next class, and resumes as soon as the register is taken.
// Bins are cleared as they are read, so the store is empty after every readout.
// The user must write scale with cfg_write_en / cfg_write_data only while the block
// is idle; the block itself does not enforce this. Zero counts as one. Synchronous
// reset rst clears the store at once, sets scale to 1 and empties the output register.
module histogram_class_binning_scaler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  hcbs_pkg::sample_t             sample,
  output logic                          result_valid,
  input  logic                          result_ready,
  output hcbs_pkg::result_t             result,
  input  logic                          cfg_write_en,
  input  logic [hcbs_pkg::SCALE_W-1:0]  cfg_write_data
);
  import hcbs_pkg::*;

  state_t state, state_next;

  logic [SCALE_W-1:0]    scale;
  logic [SCALE_W-1:0]    divisor;

  logic [COUNT_BITS-1:0] bin_mem [NUM_BINS];
  logic [NUM_BINS-1:0]   bin_valid;
  logic [COUNT_BITS-1:0] rd_data;
  logic                  rd_valid;
  logic [BIN_W-1:0]      rd_addr;
  logic                  rd_en;
  logic [COUNT_BITS-1:0] bin_value;
  logic [COUNT_BITS-1:0] inc_value;

  logic                  accept;
  logic                  in_range;
  logic [BIN_W-1:0]      inc_addr;
  logic                  last_flag;

  logic [CLASS_W-1:0]    cls;
  logic [SUB_W-1:0]      sub;
  logic                  pend;
  logic [TOTAL_W-1:0]    acc;
  logic [TOTAL_W-1:0]    sum_final;

  logic [TOTAL_W-1:0]    quo;
  logic [SCALE_W-1:0]    rem;
  logic [STEP_W-1:0]     step;
  logic [SCALE_W:0]      trial;
  logic                  fits;

  logic                  out_free;
  logic                  last_cls;

  // handshake and decode
  assign sample_ready = (state == ST_IDLE);
  assign accept       = sample_valid & sample_ready;
  assign in_range     = (sample.sample_value < BIN_LIMIT);
  assign out_free     = !result_valid || result_ready;
  assign last_cls     = (cls == CLASS_W'(NUM_CLASSES - 1));
  assign divisor      = (scale == '0) ? SCALE_W'(1) : scale;

  // scale register
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_W'(1);
    end else if (cfg_write_en) begin
      scale <= cfg_write_data;
    end
  end

  // memory address and read enable
  always_comb begin
    if (state == ST_IDLE) begin
      rd_addr = sample.sample_value[BIN_W-1:0];
    end else begin
      rd_addr = BIN_W'({cls, sub});
    end
  end
  assign rd_en = (accept && in_range) || (state == ST_SUM);

  // bin memory, registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= bin_mem[rd_addr];
    end
    if (state == ST_INC) begin
      bin_mem[inc_addr] <= inc_value;
    end
  end

  // per-bin valid flags: an unwritten or read-out bin counts as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_valid <= bin_valid[rd_addr];
      end
      if (state == ST_INC) begin
        bin_valid[inc_addr] <= 1'b1;
      end
      if (state == ST_SUM) begin
        bin_valid[rd_addr] <= 1'b0;
      end
    end
  end

  assign bin_value = rd_valid ? rd_data : '0;
  assign inc_value = (bin_value == '1) ? bin_value : bin_value + COUNT_BITS'(1);
  assign sum_final = acc + TOTAL_W'(bin_value);

  // divider step
  assign trial = {rem, quo[TOTAL_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_range) begin
            state_next = ST_INC;
          end else if (sample.last_sample) begin
            state_next = ST_SUM;
          end
        end
      end
      ST_INC:  state_next = last_flag ? ST_SUM : ST_IDLE;
      ST_SUM: begin
        if (sub == SUB_W'(BINS_PER_CLASS - 1)) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD:  state_next = ST_DIV;
      ST_DIV: begin
        if (step == STEP_W'(TOTAL_W - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = last_cls ? ST_IDLE : ST_SUM;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // class walk, accumulation and division
  always_ff @(posedge clk) begin
    if (rst) begin
      cls  <= '0;
      sub  <= '0;
      pend <= 1'b0;
      step <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            inc_addr  <= sample.sample_value[BIN_W-1:0];
            last_flag <= sample.last_sample;
            cls       <= '0;
            sub       <= '0;
            pend      <= 1'b0;
            acc       <= '0;
          end
        end
        ST_INC: begin
        end
        ST_SUM: begin
          sub  <= sub + SUB_W'(1);
          pend <= 1'b1;
          if (pend) begin
            acc <= sum_final;
          end
        end
        ST_ADD: begin
          acc  <= sum_final;
          quo  <= sum_final;
          rem  <= '0;
          step <= '0;
        end
        ST_DIV: begin
          step <= step + STEP_W'(1);
          quo  <= {quo[TOTAL_W-2:0], fits};
          rem  <= fits ? SCALE_W'(trial - {1'b0, divisor}) : trial[SCALE_W-1:0];
        end
        ST_EMIT: begin
          if (out_free && !last_cls) begin
            cls  <= cls + CLASS_W'(1);
            sub  <= '0;
            pend <= 1'b0;
            acc  <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      result.class_index <= cls;
      result.class_total <= acc;
      result.star_count  <= quo;
      result.last_class  <= last_cls;
    end
  end

endmodule

/* design/hcbs_checker.sv */
// port-level checker for the histogram class binning scaler, with its bind
module hcbs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          sample_valid,
  input logic                          sample_ready,
  input hcbs_pkg::sample_t             sample,
  input logic                          result_valid,
  input logic                          result_ready,
  input hcbs_pkg::result_t             result
);
  import hcbs_pkg::*;

  // a stalled result transaction holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // a counted or readout-starting sample leaves sample_ready low in the cycle after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready &&
    ((sample.sample_value < BIN_LIMIT) || sample.last_sample) |=> !sample_ready)
    else $error("sample taken on back-to-back cycles");

  // a quotient by a nonzero divisor never exceeds the total
  a_star_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.star_count <= result.class_total)
    else $error("star count above class total");

  // the last flag marks exactly the final class
  a_last_class: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.last_class == (result.class_index == CLASS_W'(NUM_CLASSES - 1))))
    else $error("last_class does not match class_index");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind histogram_class_binning_scaler hcbs_checker u_hcbs_checker (.*);
